// ----- rtl/core/f2m_pkg.sv -----
// shared types and constants for the flux to magnitude converter
// no dependencies
package f2m_pkg;

    localparam int unsigned NUM_STEPS = 33;
    localparam int unsigned LOG_BITS  = 30;

    localparam logic [27:0] LOG_K = 28'd202017810;
    localparam logic [30:0] ERR_K = 31'd1165761498;

    typedef enum logic [1:0] {
        REG_DIFF_MODE  = 2'd0,
        REG_ZERO_POINT = 2'd1,
        REG_REF_FLUX   = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic        valid;
        logic        inv;
        logic        last;
        logic [32:0] f;
        logic [5:0]  e;
        logic [31:0] m;
        logic [29:0] frac;
        logic [63:0] r;
        logic [32:0] q;
        logic        sat;
    } pipe_t;

endpackage

// ----- rtl/core/f2m_if.sv -----
// handshake channels of the flux to magnitude converter
// depends on nothing
interface f2m_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] flux;
    logic [31:0] flux_sigma;
    logic        last_sample;
    modport source (output valid, flux, flux_sigma, last_sample, input ready);
    modport sink (input valid, flux, flux_sigma, last_sample, output ready);
endinterface

interface f2m_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] magnitude;
    logic [31:0] magnitude_error;
    logic        invalid;
    logic        last_out;
    modport source (output valid, magnitude, magnitude_error, invalid, last_out, input ready);
    modport sink (input valid, magnitude, magnitude_error, invalid, last_out, output ready);
endinterface

interface f2m_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [31:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/f2m_step.sv -----
// one pipeline step: one log2 fraction bit by squaring (only in the first LOG_BITS steps), one quotient bit
// depends on f2m_pkg
module f2m_step #(
    parameter int unsigned STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  f2m_pkg::pipe_t  d,
    output f2m_pkg::pipe_t  q
);

    localparam int unsigned QBIT = f2m_pkg::NUM_STEPS - 1 - STEP;
    localparam int unsigned FBIT = (STEP < f2m_pkg::LOG_BITS) ? f2m_pkg::LOG_BITS - 1 - STEP : 0;

    f2m_pkg::pipe_t q_reg;
    f2m_pkg::pipe_t q_next;
    logic [63:0]    sq;
    logic [32:0]    sh;
    logic [72:0]    dsh;

    always_comb
    begin
        q_next = d;
        sq     = 64'(d.m) * 64'(d.m);
        sh     = sq[63:31];
        if (STEP < f2m_pkg::LOG_BITS)
        begin
            if (sh[32])
            begin
                q_next.m = sh[32:1];
                q_next.frac[FBIT] = 1'b1;
            end
            else
            begin
                q_next.m = sh[31:0];
            end
        end
        dsh = {34'b0, d.f, 6'b0} << QBIT;
        if ({9'b0, d.r} >= dsh)
        begin
            q_next.r       = d.r - dsh[63:0];
            q_next.q[QBIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ----- rtl/core/flux_to_magnitude_converter_core.sv -----
// top level of the flux to magnitude converter: front stages, step chain, output
// depends on f2m_pkg, f2m_if, f2m_step
//
// channel  | dir | payload
// sample   | in  | flux, flux_sigma, last_sample
// result   | out | magnitude, magnitude_error, invalid, last_out
// cfg      | in  | addr, data (register write, always ready)
//
// one item per cycle while the result is not stalled; 33 chained squaring/divide steps
// reset clears the configuration registers and all stage valid bits
// a stalled result holds the whole pipeline; nothing is dropped or repeated
module flux_to_magnitude_converter_core (
    input logic      clk,
    input logic      rst_n,
    f2m_in_if.sink   sample,
    f2m_out_if.source result,
    f2m_cfg_if.sink  cfg
);

    localparam int unsigned NS = f2m_pkg::NUM_STEPS;

    logic        diff_mode_reg;
    logic [31:0] zero_point_reg;
    logic [30:0] ref_flux_reg;

    f2m_pkg::pipe_t p0_reg, p0_next;
    f2m_pkg::pipe_t p1_reg, p1_next;
    f2m_pkg::pipe_t p2_reg, p2_next;
    f2m_pkg::pipe_t chain [NS + 1];

    logic        t_valid_reg, t_inv_reg, t_last_reg, t_neg_reg;
    logic [45:0] t_plo_reg;
    logic [44:0] t_phi_reg;
    logic [31:0] t_err_reg;

    logic        o_valid_reg;
    logic [31:0] o_mag_reg, o_mag_next;
    logic [31:0] o_err_reg;
    logic        o_inv_reg, o_last_reg;

    logic        adv;
    logic [33:0] fs;
    logic [63:0] fwide;
    logic [6:0]  lint;
    logic [36:0] lval;
    logic [36:0] aval;
    logic [63:0] tsum;
    logic [33:0] term;
    logic [33:0] mag;

    assign adv          = !o_valid_reg || result.ready;
    assign sample.ready = adv;
    assign cfg.ready    = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_mode_reg  <= 1'b0;
            zero_point_reg <= '0;
            ref_flux_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (f2m_pkg::cfg_reg_t'(cfg.addr))
                f2m_pkg::REG_DIFF_MODE:  diff_mode_reg  <= cfg.data[0];
                f2m_pkg::REG_ZERO_POINT: zero_point_reg <= cfg.data;
                f2m_pkg::REG_REF_FLUX:   ref_flux_reg   <= cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // effective flux
    always_comb
    begin
        fs = diff_mode_reg ? ({3'b0, ref_flux_reg} - {{2{sample.flux[31]}}, sample.flux})
                           : {{2{sample.flux[31]}}, sample.flux};
        p0_next       = '0;
        p0_next.valid = sample.valid;
        p0_next.inv   = fs[33] || (fs == '0);
        p0_next.last  = sample.last_sample;
        p0_next.f     = (fs[33] || (fs == '0)) ? '0 : fs[32:0];
        p0_next.r     = {32'b0, sample.flux_sigma};
    end

    // leading one and sigma product
    always_comb
    begin
        p1_next   = p0_reg;
        p1_next.e = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (p0_reg.f[i])
            begin
                p1_next.e = 6'(i);
            end
        end
        p1_next.r = 64'(p0_reg.r[31:0]) * 64'(f2m_pkg::ERR_K);
    end

    // normalize, add rounding half, overflow check
    always_comb
    begin
        p2_next = p1_reg;
        fwide   = {31'b0, p1_reg.f};
        if (p1_reg.e >= 6'd31)
        begin
            fwide = fwide >> (p1_reg.e - 6'd31);
        end
        else
        begin
            fwide = fwide << (6'd31 - p1_reg.e);
        end
        p2_next.m   = fwide[31:0];
        p2_next.r   = p1_reg.r + {26'b0, p1_reg.f, 5'b0};
        p2_next.sat = {9'b0, p2_next.r} >= {1'b0, p1_reg.f, 6'b0, 33'b0};
        p2_next.q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else if (adv)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    assign chain[0] = p2_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        f2m_step #(
            .STEP (k)
        ) u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d     (chain[k]),
            .q     (chain[k + 1])
        );
    end

    // log2 in q.30 and its magnitude
    always_comb
    begin
        lint = 7'({1'b0, chain[NS].e}) - 7'd16;
        lval = {lint, 30'b0} | {7'b0, chain[NS].frac};
        aval = lval[36] ? (37'd0 - lval) : lval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg <= chain[NS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_inv_reg  <= chain[NS].inv;
            t_last_reg <= chain[NS].last;
            t_neg_reg  <= lval[36];
            t_plo_reg  <= 46'(aval[17:0]) * 46'(f2m_pkg::LOG_K);
            t_phi_reg  <= 45'(aval[34:18]) * 45'(f2m_pkg::LOG_K);
            t_err_reg  <= (chain[NS].sat || chain[NS].q[32]) ? 32'hFFFF_FFFF
                                                             : chain[NS].q[31:0];
        end
    end

    // round, subtract from zero point, saturate
    always_comb
    begin
        tsum = ({19'b0, t_phi_reg} << 18) + {18'b0, t_plo_reg} + (64'd1 << 33);
        term = t_neg_reg ? (34'd0 - {5'b0, tsum[62:34]}) : {5'b0, tsum[62:34]};
        mag  = {{2{zero_point_reg[31]}}, zero_point_reg} - term;
        if (!mag[33] && (mag[32:31] != 2'b00))
        begin
            o_mag_next = 32'h7FFF_FFFF;
        end
        else if (mag[33] && (mag[32:31] != 2'b11))
        begin
            o_mag_next = 32'h8000_0000;
        end
        else
        begin
            o_mag_next = mag[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_mag_reg  <= t_inv_reg ? '0 : o_mag_next;
            o_err_reg  <= t_inv_reg ? '0 : t_err_reg;
            o_inv_reg  <= t_inv_reg;
            o_last_reg <= t_last_reg;
        end
    end

    assign result.valid           = o_valid_reg;
    assign result.magnitude       = o_mag_reg;
    assign result.magnitude_error = o_err_reg;
    assign result.invalid         = o_inv_reg;
    assign result.last_out        = o_last_reg;

endmodule

// ----- test/tb_f2m_scoreboard.sv -----
`timescale 1ns / 1ps
// result checker for the flux to magnitude converter testbench
// holds its own copy of the configuration and predicts each result; depends on nothing
class f2m_scoreboard;

    typedef struct {
        logic [31:0] magnitude;
        logic [31:0] magnitude_error;
        logic        invalid;
        logic        last_out;
    } f2m_result_t;

    bit              diff_mode;
    logic [31:0]     zero_pt;
    logic [30:0]     ref_flux;
    f2m_result_t     pending[$];
    int unsigned     errors;

    function new();
        diff_mode = 1'b0;
        zero_pt   = '0;
        ref_flux  = '0;
        errors    = 0;
    endfunction

    // log2 of a positive Q16.16 value, result in Q.30
    function longint log2_q30(logic [63:0] f);
        int          e;
        logic [63:0] m;
        longint      frac;
        e    = 0;
        frac = 0;
        for (int i = 0; i < 64; i++)
            if (f[i])
                e = i;
        m = (e >= 31) ? (f >> (e - 31)) : (f << (31 - e));
        for (int i = 1; i <= 30; i++)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac = frac | (longint'(1) << (30 - i));
            end
        end
        return longint'(e - 16) * (longint'(1) << 30) + frac;
    endfunction

    function void note_sample(logic [31:0] flux, logic [31:0] sigma, logic last);
        f2m_result_t r;
        longint      f;
        longint      l;
        longint      term;
        longint      mag;
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] den;
        logic [95:0] q;
        f = diff_mode ? (longint'({1'b0, ref_flux}) - longint'($signed(flux)))
                      : longint'($signed(flux));
        r.last_out = last;
        if (f <= 0)
        begin
            r.magnitude       = '0;
            r.magnitude_error = '0;
            r.invalid         = 1'b1;
        end
        else
        begin
            l    = log2_q30(f);
            a    = (l < 0) ? -l : l;
            t    = (a * 64'd202017810 + (64'd1 << 33)) >> 34;
            term = (l < 0) ? -longint'(t) : longint'(t);
            mag  = longint'($signed(zero_pt)) - term;
            if (mag > 64'sd2147483647)
                mag = 64'sd2147483647;
            if (mag < -64'sd2147483648)
                mag = -64'sd2147483648;
            den = f << 6;
            q   = ({64'd0, sigma} * 96'd1165761498 + den / 2) / den;
            if (q > 96'hFFFF_FFFF)
                q = 96'hFFFF_FFFF;
            r.magnitude       = mag[31:0];
            r.magnitude_error = q[31:0];
            r.invalid         = 1'b0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] mag, logic [31:0] err, logic inv, logic last);
        f2m_result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected result mag %h err %h inv %b last %b",
                     $time, mag, err, inv, last);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (mag !== e.magnitude)
        begin
            $display("%0t magnitude exp %h got %h", $time, e.magnitude, mag);
            errors++;
        end
        if (err !== e.magnitude_error)
        begin
            $display("%0t magnitude_error exp %h got %h", $time, e.magnitude_error, err);
            errors++;
        end
        if (inv !== e.invalid)
        begin
            $display("%0t invalid exp %b got %b", $time, e.invalid, inv);
            errors++;
        end
        if (last !== e.last_out)
        begin
            $display("%0t last_out exp %b got %b", $time, e.last_out, last);
            errors++;
        end
    endfunction

endclass

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for flux_to_magnitude_converter_core: directed and random samples
// depends on f2m_pkg, f2m_if, tb_f2m_scoreboard and the core
module tb_top;

    localparam int LATENCY   = 38;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;

    f2m_in_if  sample();
    f2m_out_if result();
    f2m_cfg_if cfg();

    flux_to_magnitude_converter_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    f2m_scoreboard mag_board;
    int  src_idle;
    int  snk_idle;
    int  hold_off;
    int  cycle;
    bit  failed;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > MAX_CYCLE)
        begin
            $display("** flux_to_magnitude_converter_core: FAILED **");
            $finish;
        end
        if (sample.valid && sample.ready)
            mag_board.note_sample(sample.flux, sample.flux_sigma, sample.last_sample);
        if (result.valid && result.ready)
            mag_board.check_result(result.magnitude, result.magnitude_error,
                                   result.invalid, result.last_out);
    end

    // receiver side readiness with long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= snk_idle);
    end

    task automatic write_reg(f2m_pkg::cfg_reg_t idx, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            f2m_pkg::REG_DIFF_MODE:  mag_board.diff_mode = data[0];
            f2m_pkg::REG_ZERO_POINT: mag_board.zero_pt   = data;
            f2m_pkg::REG_REF_FLUX:   mag_board.ref_flux  = data[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_sample(logic [31:0] flux, logic [31:0] sigma, logic last);
        while ($urandom_range(99) < src_idle)
        begin
            sample.valid <= 1'b0;
            @(negedge clk);
        end
        sample.valid       <= 1'b1;
        sample.flux        <= flux;
        sample.flux_sigma  <= sigma;
        sample.last_sample <= last;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        while (mag_board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_flux();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255);
            2: return 32'h8000_0000 | $urandom_range(255);
            3: return $urandom >> $urandom_range(31);
            4: return -($urandom >> $urandom_range(31));
            default: return $urandom_range(32'h0100_0000, 1);
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_sample(rand_flux(), ($urandom_range(3) == 0) ? $urandom
                                    : $urandom >> $urandom_range(31),
                        $urandom_range(1));
    endtask

    initial
    begin
        logic [31:0] dir_flux[14];
        mag_board    = new();
        rst_n        = 1'b0;
        cycle        = 0;
        src_idle     = 0;
        snk_idle     = 0;
        hold_off     = 0;
        sample.valid = 1'b0;
        sample.flux  = '0;
        sample.flux_sigma  = '0;
        sample.last_sample = 1'b0;
        result.ready = 1'b0;
        cfg.valid    = 1'b0;
        cfg.addr     = f2m_pkg::REG_DIFF_MODE;
        cfg.data     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_flux = '{32'h0000_0001, 32'h0000_0002, 32'h0000_FFFF, 32'h0001_0000,
                     32'h0001_0001, 32'h7FFF_FFFF, 32'h4000_0000, 32'h0000_0000,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_8000,
                     32'h7FFF_0000, 32'h0000_0003};
        write_reg(f2m_pkg::REG_ZERO_POINT, 32'h7FFF_FFFF);
        foreach (dir_flux[i])
            send_sample(dir_flux[i], (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, i[0]);
        drain();
        write_reg(f2m_pkg::REG_ZERO_POINT, 32'h8000_0000);
        send_sample(32'h0000_0001, 32'h0001_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        drain();
        write_reg(f2m_pkg::REG_DIFF_MODE, 32'd1);
        write_reg(f2m_pkg::REG_REF_FLUX, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_sample(32'h7FFF_FFFE, 32'hFFFF_FFFF, 1'b1);
        drain();
        write_reg(f2m_pkg::REG_UNUSED, 32'hFFFF_FFFF);

        src_idle = 19;
        snk_idle = 67;
        write_reg(f2m_pkg::REG_ZERO_POINT, 32'h1800_0000);
        write_reg(f2m_pkg::REG_REF_FLUX, $urandom >> 1);
        random_phase(150);
        drain();

        write_reg(f2m_pkg::REG_DIFF_MODE, 32'd0);
        write_reg(f2m_pkg::REG_ZERO_POINT, $urandom);
        src_idle = 67;
        snk_idle = 19;
        random_phase(150);
        drain();

        write_reg(f2m_pkg::REG_DIFF_MODE, 32'd1);
        write_reg(f2m_pkg::REG_REF_FLUX, 32'd0);
        src_idle = 0;
        snk_idle = 0;
        hold_off = 150;
        random_phase(130);
        drain();

        failed = (mag_board.errors != 0);
        if (!failed)
            $display("** flux_to_magnitude_converter_core: PASSED **");
        else
            $display("** flux_to_magnitude_converter_core: FAILED **");
        $finish;
    end

endmodule
